### sv/uet_pkg.sv
package uet_pkg;

  localparam int ActW   = 2;
  localparam int TimeW  = 32;
  localparam int CountW = 16;
  localparam int EvW    = 2;
  localparam int CfgAw  = 1;
  localparam int CfgDw  = 16;
  localparam int InDw   = 48;
  localparam int OutDw  = 24;

  localparam logic [ActW-1:0] ACT_START   = 2'd0;
  localparam logic [ActW-1:0] ACT_TICK    = 2'd1;
  localparam logic [ActW-1:0] ACT_CAPTURE = 2'd2;
  localparam logic [ActW-1:0] ACT_FETCH   = 2'd3;

  localparam logic [EvW-1:0] EV_NONE    = 2'd0;
  localparam logic [EvW-1:0] EV_DONE    = 2'd1;
  localparam logic [EvW-1:0] EV_TIMEOUT = 2'd2;

  localparam logic [CfgAw-1:0] REG_TIMER_TOP  = 1'd0;
  localparam logic [CfgAw-1:0] REG_TIMEOUT_MS = 1'd1;

  localparam logic [CountW-1:0] TIMER_TOP_RST  = 16'hFFFF;
  localparam logic [CountW-1:0] TIMEOUT_MS_RST = 16'd50;

  typedef struct packed {
    logic              trigger;
    logic [EvW-1:0]    event_res;
    logic [CountW-1:0] echo_width;
    logic              busy_res;
  } uet_res_t;

endpackage

### sv/uet_core.sv
module uet_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [uet_pkg::CfgAw-1:0]    cfg_addr,
  input  logic [uet_pkg::CfgDw-1:0]    cfg_wdata,
  input  logic                         accept,
  input  logic [uet_pkg::ActW-1:0]     action,
  input  logic [uet_pkg::TimeW-1:0]    now_ms,
  input  logic [uet_pkg::CountW-1:0]   capture_value,
  output uet_pkg::uet_res_t            res
);
  import uet_pkg::*;

  logic [CountW-1:0] timer_top_r;
  logic [CountW-1:0] timeout_ms_r;
  logic              active_r, active_nxt;
  logic              await_r, await_nxt;
  logic              done_r, done_nxt;
  logic              tmo_r, tmo_nxt;
  logic [CountW-1:0] rise_r, rise_nxt;
  logic [CountW-1:0] width_r, width_nxt;
  logic [TimeW-1:0]  start_r, start_nxt;

  logic [TimeW-1:0]  elapsed;
  logic [CountW-1:0] width_calc;

  assign elapsed = now_ms - start_r;

  always_comb begin
    if (capture_value >= rise_r) begin
      width_calc = capture_value - rise_r;
    end else begin
      width_calc = timer_top_r - rise_r + capture_value + 16'd1;
    end
  end

  always_comb begin
    active_nxt     = active_r;
    await_nxt      = await_r;
    done_nxt       = done_r;
    tmo_nxt        = tmo_r;
    rise_nxt       = rise_r;
    width_nxt      = width_r;
    start_nxt      = start_r;
    res.trigger    = 1'b0;
    res.event_res  = EV_NONE;
    res.echo_width = '0;
    unique case (action)
      ACT_START: begin
        if (!active_r) begin
          await_nxt   = 1'b0;
          done_nxt    = 1'b0;
          tmo_nxt     = 1'b0;
          active_nxt  = 1'b1;
          start_nxt   = now_ms;
          res.trigger = 1'b1;
        end
      end
      ACT_TICK: begin
        if (active_r && (elapsed >= {{(TimeW-CountW){1'b0}}, timeout_ms_r})) begin
          active_nxt = 1'b0;
          done_nxt   = 1'b0;
          await_nxt  = 1'b0;
          tmo_nxt    = 1'b1;
        end
      end
      ACT_CAPTURE: begin
        if (active_r) begin
          if (!await_r) begin
            rise_nxt  = capture_value;
            await_nxt = 1'b1;
          end else begin
            width_nxt  = width_calc;
            await_nxt  = 1'b0;
            active_nxt = 1'b0;
            done_nxt   = 1'b1;
          end
        end
      end
      ACT_FETCH: begin
        if (done_r) begin
          res.event_res  = EV_DONE;
          res.echo_width = width_r;
          done_nxt       = 1'b0;
        end else if (tmo_r) begin
          res.event_res = EV_TIMEOUT;
          tmo_nxt       = 1'b0;
        end
      end
      default: ;
    endcase
    res.busy_res = active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_top_r  <= TIMER_TOP_RST;
      timeout_ms_r <= TIMEOUT_MS_RST;
      active_r     <= 1'b0;
      await_r      <= 1'b0;
      done_r       <= 1'b0;
      tmo_r        <= 1'b0;
      rise_r       <= '0;
      width_r      <= '0;
      start_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_TIMER_TOP:  timer_top_r  <= cfg_wdata;
          REG_TIMEOUT_MS: timeout_ms_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        active_r <= active_nxt;
        await_r  <= await_nxt;
        done_r   <= done_nxt;
        tmo_r    <= tmo_nxt;
        rise_r   <= rise_nxt;
        width_r  <= width_nxt;
        start_r  <= start_nxt;
      end
    end
  end

endmodule

### sv/uet_out_buf.sv
module uet_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  uet_pkg::uet_res_t in_res,
  output logic              out_valid,
  input  logic              out_ready,
  output uet_pkg::uet_res_t out_res
);
  import uet_pkg::*;

  logic     out_v_r;
  logic     skid_v_r;
  uet_res_t out_r;
  uet_res_t skid_r;
  logic     take;

  assign in_ready  = !skid_v_r;
  assign take      = in_valid && !skid_v_r;
  assign out_valid = out_v_r;
  assign out_res   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (skid_v_r) begin
        if (out_ready) begin
          skid_v_r <= 1'b0;
        end
      end else if (take) begin
        if (!out_v_r || out_ready) begin
          out_v_r <= 1'b1;
        end else begin
          skid_v_r <= 1'b1;
        end
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_ready) begin
        out_r <= skid_r;
      end
    end else if (take) begin
      if (!out_v_r || out_ready) begin
        out_r <= in_res;
      end else begin
        skid_r <= in_res;
      end
    end
  end

endmodule

### sv/ultrasonic_echo_timer.sv
// Echo-ranging pulse-width capture controller.
// Input channel (in_*): one item per event. in_tuser carries the action
// (start, millisecond tick, echo edge capture, fetch event); in_tdata
// carries now_ms and capture_value.
// Result channel (out_*): exactly one result item per input item, in
// order. out_tuser carries the event code, out_tdata the trigger flag,
// echo width and busy flag.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr
// (0 timer top, 1 timeout in ms); write only while the block is idle.
// An accepted item's result is registered into the result register, or
// into the skid register while the receiver stalls. Throughput: one item per
// cycle while in_tready is high, set by the single state update and result register.
// Reset (rst_n low, synchronous): measurement idle, flags cleared, timer
// top 65535, timeout 50 ms, no result pending.
// Receiver stall: a two-entry output stage (result register plus skid
// register) holds results; in_tready drops only when both are full.
module ultrasonic_echo_timer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [uet_pkg::CfgAw-1:0] cfg_addr,
  input  logic [uet_pkg::CfgDw-1:0] cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [uet_pkg::InDw-1:0]  in_tdata,   // now_ms[31:0], capture_value[47:32]
  input  logic [uet_pkg::ActW-1:0]  in_tuser,   // action[1:0]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [uet_pkg::OutDw-1:0] out_tdata,  // trigger[0], echo_width[16:1], busy_res[17]
  output logic [uet_pkg::EvW-1:0]   out_tuser   // event_res[1:0]
);
  import uet_pkg::*;

  logic     accept;
  uet_res_t core_res;
  uet_res_t buf_res;

  assign accept = in_tvalid && in_tready;

  uet_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .accept        (accept),
    .action        (in_tuser),
    .now_ms        (in_tdata[TimeW-1:0]),
    .capture_value (in_tdata[TimeW+CountW-1:TimeW]),
    .res           (core_res)
  );

  uet_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_res    (core_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (buf_res)
  );

  assign out_tdata = {{(OutDw-CountW-2){1'b0}}, buf_res.busy_res, buf_res.echo_width,
                      buf_res.trigger};
  assign out_tuser = buf_res.event_res;

endmodule
